// ===== src/sstu_pkg.sv =====
// ----------------------------------------------------------------------------
// Slice space transform unit: shared types, constants and helpers
// Fixed-point formats, operation and register codes, divider lane type.
// ----------------------------------------------------------------------------
package sstu_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int AXIS_FRAC_BITS  = 14;
    localparam int SH_FW           = COORD_FRAC_BITS + AXIS_FRAC_BITS;

    localparam int COORD_W  = 32;
    localparam int AXIS_W   = 16;
    localparam int AXREG_W  = 3 * AXIS_W;
    localparam int CFG_W    = AXREG_W;
    localparam int PROD_W   = AXIS_W + COORD_W;
    localparam int DOT_W    = PROD_W + 1;
    localparam int MAG_W    = 48;
    localparam int HALF_W   = MAG_W / 2;
    localparam int PP_W     = HALF_W + COORD_W;
    localparam int W_LIM_B  = 43;
    localparam int W_W      = W_LIM_B + 1;
    localparam int QUO_W    = 32;
    localparam int NUM_W    = 96;
    localparam int REM_W    = MAG_W;

    localparam logic [2:0] FUNC_PT_FROM  = 3'd0;
    localparam logic [2:0] FUNC_PT_TO    = 3'd1;
    localparam logic [2:0] FUNC_VEC_FROM = 3'd2;
    localparam logic [2:0] FUNC_VEC_TO   = 3'd3;
    localparam logic [2:0] FUNC_RAY      = 3'd4;

    localparam logic [2:0] REG_AXIS_ACROSS = 3'd0;
    localparam logic [2:0] REG_AXIS_UP     = 3'd1;
    localparam logic [2:0] REG_AXIS_DEPTH  = 3'd2;
    localparam logic [2:0] REG_VOXEL_SIZE  = 3'd3;
    localparam logic [2:0] REG_INV_VOXEL   = 3'd4;
    localparam logic [2:0] REG_SLICE_INDEX = 3'd5;

    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic             over;
        logic             neg;
    } lane_t;

    typedef struct packed {
        logic                     is_ray;
        logic                     par;
        logic                     sat;
        logic [2:0][COORD_W-1:0]  res;
        logic [REM_W-1:0]         dm;
        lane_t                    lane_end;
        lane_t                    lane_start;
    } div_item_t;

    function automatic logic signed [AXIS_W-1:0] axis_comp(input logic [AXREG_W-1:0] a,
                                                           input int unsigned j);
        axis_comp = a[AXIS_W*j +: AXIS_W];
    endfunction

    // {flag, value}
    function automatic logic [COORD_W:0] sat32(input logic signed [63:0] v);
        logic [COORD_W:0] r;
        if (v > S32_MAX) begin
            r = {1'b1, S32_MAX[COORD_W-1:0]};
        end else if (v < S32_MIN) begin
            r = {1'b1, S32_MIN[COORD_W-1:0]};
        end else begin
            r = {1'b0, v[COORD_W-1:0]};
        end
        return r;
    endfunction

    // one restoring division step
    function automatic lane_t lane_step(input lane_t l, input logic [REM_W-1:0] dm);
        lane_t          r;
        logic [REM_W:0] t;
        logic           ge;
        t  = {l.rem, l.low[QUO_W-1]};
        ge = t >= {1'b0, dm};
        r  = l;
        r.rem = ge ? REM_W'(t - {1'b0, dm}) : t[REM_W-1:0];
        r.low = {l.low[QUO_W-2:0], 1'b0};
        r.quo = {l.quo[QUO_W-2:0], ge};
        return r;
    endfunction

    // round to nearest, clamp, apply sign: {flag, value}
    function automatic logic [COORD_W:0] lane_finish(input lane_t l, input logic [REM_W-1:0] dm);
        logic           rnd;
        logic [QUO_W:0] qr;
        logic [QUO_W:0] cap;
        logic           sat;
        rnd = {l.rem, 1'b0} >= {1'b0, dm};
        qr  = {1'b0, l.quo} + (QUO_W+1)'(rnd);
        cap = l.neg ? ((QUO_W+1)'(1) << (QUO_W-1)) : ((QUO_W+1)'(1) << (QUO_W-1)) - (QUO_W+1)'(1);
        sat = l.over || (qr > cap);
        if (sat) begin
            qr = cap;
        end
        return {sat, l.neg ? COORD_W'((QUO_W+1)'(0) - qr) : qr[COORD_W-1:0]};
    endfunction

endpackage

// ===== src/slice_space_transform_unit.sv =====
// ----------------------------------------------------------------------------
// Slice space transform unit
// Throughput: one beat per cycle while the output is taken; the 32-step
// restoring divider for the ray intersect is fully pipelined, one quotient bit
// per stage.
// Reset: synchronous, active low; clears all stage valids and loads the
// identity basis, unit voxel size and slice zero.
// ----------------------------------------------------------------------------
module slice_space_transform_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [sstu_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_func,
    input  logic signed [31:0]           s_in_x,
    input  logic signed [31:0]           s_in_y,
    input  logic signed [31:0]           s_in_z,
    input  logic signed [31:0]           s_dir_x,
    input  logic signed [31:0]           s_dir_y,
    input  logic signed [31:0]           s_dir_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_out_x,
    output logic signed [31:0]           m_out_y,
    output logic signed [31:0]           m_out_z,
    output logic                         m_parallel_flag,
    output logic                         m_saturated
);

    localparam int PRE = 6;
    localparam int NST = PRE + sstu_pkg::QUO_W + 1;
    localparam int LASTD = NST - 2;

    // ---------------- configuration ----------------
    logic [sstu_pkg::AXREG_W-1:0] axis_reg [3];
    logic [31:0]                  voxel_size_reg;
    logic [31:0]                  inv_voxel_reg;
    logic signed [31:0]           slice_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg[0]     <= sstu_pkg::AXREG_W'(1) << sstu_pkg::AXIS_FRAC_BITS;
            axis_reg[1]     <= sstu_pkg::AXREG_W'(1) << (sstu_pkg::AXIS_FRAC_BITS + 16);
            axis_reg[2]     <= sstu_pkg::AXREG_W'(1) << (sstu_pkg::AXIS_FRAC_BITS + 32);
            voxel_size_reg  <= 32'(1) << sstu_pkg::COORD_FRAC_BITS;
            inv_voxel_reg   <= 32'(1) << sstu_pkg::COORD_FRAC_BITS;
            slice_index_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                sstu_pkg::REG_AXIS_ACROSS: axis_reg[0] <= cfg_wdata;
                sstu_pkg::REG_AXIS_UP:     axis_reg[1] <= cfg_wdata;
                sstu_pkg::REG_AXIS_DEPTH:  axis_reg[2] <= cfg_wdata;
                sstu_pkg::REG_VOXEL_SIZE:  voxel_size_reg <= cfg_wdata[31:0];
                sstu_pkg::REG_INV_VOXEL:   inv_voxel_reg <= cfg_wdata[31:0];
                sstu_pkg::REG_SLICE_INDEX: slice_index_reg <= $signed(cfg_wdata[31:0]);
                default: ;
            endcase
        end
    end

    logic signed [47:0] slice_off;
    assign slice_off = 48'(slice_index_reg) <<< sstu_pkg::COORD_FRAC_BITS;

    // ---------------- flow control ----------------
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !valid_reg[NST-1] || m_ready;
        for (int i = 0; i < NST - 1; i++) begin
            en[i] = en[NST-1] || !valid_reg[i];
        end
        for (int i = 0; i < NST; i++) begin
            if (en[i]) begin
                valid_next[i] = (i == 0) ? s_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end else if (i < NST - 1 && en[i + 1]) begin
                // item moved on while this stage held
                valid_next[i] = 1'b0;
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[NST-1];

    logic signed [31:0] pin [3];
    logic signed [31:0] din [3];
    assign pin[0] = s_in_x;
    assign pin[1] = s_in_y;
    assign pin[2] = s_in_z;
    assign din[0] = s_dir_x;
    assign din[1] = s_dir_y;
    assign din[2] = s_dir_z;

    // ---------------- stage 1: axis products ----------------
    logic [2:0]                          s1_func_reg;
    logic signed [sstu_pkg::PROD_W-1:0]  s1_prod_reg [3][3];
    logic signed [sstu_pkg::PROD_W-1:0]  s1_pdir_reg [3];
    logic signed [sstu_pkg::DOT_W-1:0]   s1_pw_reg [3];
    logic signed [63:0]                  s1_sv_reg;
    logic signed [sstu_pkg::PROD_W-1:0]  s1_prod_next [3][3];
    logic signed [sstu_pkg::PROD_W-1:0]  s1_pdir_next [3];
    logic signed [sstu_pkg::DOT_W-1:0]   s1_pw_next [3];
    logic signed [63:0]                  s1_sv_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                s1_prod_next[k][j] = sstu_pkg::PROD_W'(sstu_pkg::axis_comp(axis_reg[k], j))
                                   * sstu_pkg::PROD_W'(pin[j]);
            end
            s1_pdir_next[k] = sstu_pkg::PROD_W'(sstu_pkg::axis_comp(axis_reg[2], k))
                            * sstu_pkg::PROD_W'(din[k]);
        end
        s1_pw_next[0] = sstu_pkg::DOT_W'(pin[0]);
        s1_pw_next[1] = sstu_pkg::DOT_W'(pin[1]);
        s1_pw_next[2] = sstu_pkg::DOT_W'(pin[2])
                      + ((s_func == sstu_pkg::FUNC_PT_TO) ? sstu_pkg::DOT_W'(slice_off)
                                                          : sstu_pkg::DOT_W'(0));
        s1_sv_next = 64'(slice_index_reg) * $signed({32'b0, voxel_size_reg});
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_func_reg  <= s_func;
            s1_prod_reg  <= s1_prod_next;
            s1_pdir_reg  <= s1_pdir_next;
            s1_pw_reg    <= s1_pw_next;
            s1_sv_reg    <= s1_sv_next;
        end
    end

    // ---------------- stage 2: dot sums, voxel scale partials ----------------
    logic [2:0]                          s2_func_reg;
    logic signed [sstu_pkg::DOT_W-1:0]   s2_dot_reg [3];
    logic signed [sstu_pkg::DOT_W-1:0]   s2_dd_reg;
    logic [sstu_pkg::PP_W-1:0]           s2_wlo_reg [3];
    logic [sstu_pkg::PP_W-1:0]           s2_whi_reg [3];
    logic [2:0]                          s2_wneg_reg;
    logic signed [63:0]                  s2_sv_reg;
    logic signed [sstu_pkg::DOT_W-1:0]   s2_dot_next [3];
    logic signed [sstu_pkg::DOT_W-1:0]   s2_dd_next;
    logic [sstu_pkg::PP_W-1:0]           s2_wlo_next [3];
    logic [sstu_pkg::PP_W-1:0]           s2_whi_next [3];
    logic [2:0]                          s2_wneg_next;

    always_comb begin
        logic [sstu_pkg::DOT_W-1:0] m;
        for (int k = 0; k < 3; k++) begin
            s2_dot_next[k] = sstu_pkg::DOT_W'(s1_prod_reg[k][0])
                           + sstu_pkg::DOT_W'(s1_prod_reg[k][1])
                           + sstu_pkg::DOT_W'(s1_prod_reg[k][2]);
            s2_wneg_next[k] = s1_pw_reg[k] < 0;
            m = s2_wneg_next[k] ? -s1_pw_reg[k] : s1_pw_reg[k];
            s2_wlo_next[k] = sstu_pkg::PP_W'(m[sstu_pkg::HALF_W-1:0])
                           * sstu_pkg::PP_W'(voxel_size_reg);
            s2_whi_next[k] = sstu_pkg::PP_W'(m[sstu_pkg::MAG_W-1:sstu_pkg::HALF_W])
                           * sstu_pkg::PP_W'(voxel_size_reg);
        end
        s2_dd_next = sstu_pkg::DOT_W'(s1_pdir_reg[0]) + sstu_pkg::DOT_W'(s1_pdir_reg[1])
                   + sstu_pkg::DOT_W'(s1_pdir_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_func_reg <= s1_func_reg;
            s2_dot_reg  <= s2_dot_next;
            s2_dd_reg   <= s2_dd_next;
            s2_wlo_reg  <= s2_wlo_next;
            s2_whi_reg  <= s2_whi_next;
            s2_wneg_reg <= s2_wneg_next;
            s2_sv_reg   <= s1_sv_reg;
        end
    end

    // ---------------- stage 3: from-world partials, w clamp, ray numerators ----------------
    localparam int SUM_W = 2 * sstu_pkg::HALF_W + 32 + 2;

    logic [2:0]                          s3_func_reg;
    logic [sstu_pkg::PP_W-1:0]           s3_flo_reg [3];
    logic [sstu_pkg::PP_W-1:0]           s3_fhi_reg [3];
    logic [2:0]                          s3_fneg_reg;
    logic signed [sstu_pkg::W_W-1:0]     s3_w_reg [3];
    logic                                s3_wsat_reg;
    logic signed [sstu_pkg::NUM_W-1:0]   s3_num_reg;
    logic signed [sstu_pkg::NUM_W-1:0]   s3_nst_reg;
    logic signed [sstu_pkg::DOT_W-1:0]   s3_dd_reg;
    logic                                s3_par_reg;
    logic [sstu_pkg::PP_W-1:0]           s3_flo_next [3];
    logic [sstu_pkg::PP_W-1:0]           s3_fhi_next [3];
    logic [2:0]                          s3_fneg_next;
    logic signed [sstu_pkg::W_W-1:0]     s3_w_next [3];
    logic                                s3_wsat_next;
    logic signed [sstu_pkg::NUM_W-1:0]   s3_num_next;
    logic signed [sstu_pkg::NUM_W-1:0]   s3_nst_next;

    always_comb begin
        logic [sstu_pkg::DOT_W-1:0] m;
        logic [SUM_W-1:0]           q;
        logic [SUM_W-1:0]           cap;
        s3_wsat_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            s3_fneg_next[k] = s2_dot_reg[k] < 0;
            m = s3_fneg_next[k] ? -s2_dot_reg[k] : s2_dot_reg[k];
            s3_flo_next[k] = sstu_pkg::PP_W'(m[sstu_pkg::HALF_W-1:0])
                           * sstu_pkg::PP_W'(inv_voxel_reg);
            s3_fhi_next[k] = sstu_pkg::PP_W'(m[sstu_pkg::MAG_W-1:sstu_pkg::HALF_W])
                           * sstu_pkg::PP_W'(inv_voxel_reg);
            q = ((SUM_W'(s2_whi_reg[k]) << sstu_pkg::HALF_W) + SUM_W'(s2_wlo_reg[k])
                 + (SUM_W'(1) << (sstu_pkg::COORD_FRAC_BITS - 1))) >> sstu_pkg::COORD_FRAC_BITS;
            cap = s2_wneg_reg[k] ? (SUM_W'(1) << sstu_pkg::W_LIM_B)
                                 : (SUM_W'(1) << sstu_pkg::W_LIM_B) - SUM_W'(1);
            if (q > cap) begin
                q = cap;
                s3_wsat_next = 1'b1;
            end
            s3_w_next[k] = s2_wneg_reg[k] ? sstu_pkg::W_W'(0) - q[sstu_pkg::W_W-1:0]
                                          : q[sstu_pkg::W_W-1:0];
        end
        s3_num_next = (sstu_pkg::NUM_W'(s2_sv_reg) <<< sstu_pkg::SH_FW)
                    - (sstu_pkg::NUM_W'(s2_dot_reg[2]) <<< sstu_pkg::COORD_FRAC_BITS);
        s3_nst_next = s3_num_next
                    + $signed(sstu_pkg::NUM_W'(voxel_size_reg) << sstu_pkg::SH_FW);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s3_func_reg <= s2_func_reg;
            s3_flo_reg  <= s3_flo_next;
            s3_fhi_reg  <= s3_fhi_next;
            s3_fneg_reg <= s3_fneg_next;
            s3_w_reg    <= s3_w_next;
            s3_wsat_reg <= s3_wsat_next;
            s3_num_reg  <= s3_num_next;
            s3_nst_reg  <= s3_nst_next;
            s3_dd_reg   <= s2_dd_reg;
            s3_par_reg  <= s2_dd_reg == '0;
        end
    end

    // ---------------- stage 4: from-world round, to-world products, magnitudes ----------------
    localparam int FV_W = 52;
    localparam int TP_W = sstu_pkg::W_W + sstu_pkg::AXIS_W;

    logic [2:0]                          s4_func_reg;
    logic signed [FV_W-1:0]              s4_fv_reg [3];
    logic signed [TP_W-1:0]              s4_tp_reg [3][3];
    logic                                s4_wsat_reg;
    logic [sstu_pkg::NUM_W-1:0]          s4_nmag_reg;
    logic [sstu_pkg::NUM_W-1:0]          s4_smag_reg;
    logic                                s4_nneg_reg;
    logic                                s4_sneg_reg;
    logic [sstu_pkg::REM_W-1:0]          s4_dm_reg;
    logic                                s4_ddneg_reg;
    logic                                s4_par_reg;
    logic signed [FV_W-1:0]              s4_fv_next [3];
    logic signed [TP_W-1:0]              s4_tp_next [3][3];
    logic [sstu_pkg::DOT_W-1:0]          s4_dd_abs;

    always_comb begin
        logic [SUM_W-1:0] q;
        for (int k = 0; k < 3; k++) begin
            q = ((SUM_W'(s3_fhi_reg[k]) << sstu_pkg::HALF_W) + SUM_W'(s3_flo_reg[k])
                 + (SUM_W'(1) << (sstu_pkg::SH_FW - 1))) >> sstu_pkg::SH_FW;
            s4_fv_next[k] = s3_fneg_reg[k] ? FV_W'(0) - q[FV_W-1:0] : q[FV_W-1:0];
            for (int j = 0; j < 3; j++) begin
                s4_tp_next[k][j] = TP_W'(s3_w_reg[k])
                                 * TP_W'(sstu_pkg::axis_comp(axis_reg[k], j));
            end
        end
        s4_dd_abs = (s3_dd_reg < 0) ? -s3_dd_reg : s3_dd_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s4_func_reg  <= s3_func_reg;
            s4_fv_reg    <= s4_fv_next;
            s4_tp_reg    <= s4_tp_next;
            s4_wsat_reg  <= s3_wsat_reg;
            s4_nmag_reg  <= (s3_num_reg < 0) ? -s3_num_reg : s3_num_reg;
            s4_smag_reg  <= (s3_nst_reg < 0) ? -s3_nst_reg : s3_nst_reg;
            s4_nneg_reg  <= s3_num_reg < 0;
            s4_sneg_reg  <= s3_nst_reg < 0;
            s4_dm_reg    <= s4_dd_abs[sstu_pkg::REM_W-1:0];
            s4_ddneg_reg <= s3_dd_reg < 0;
            s4_par_reg   <= s3_par_reg;
        end
    end

    // ---------------- stage 5: offset and clamp, to-world sums, divider set-up ----------------
    localparam int TS_W = TP_W + 2;

    logic [2:0]                          s5_func_reg;
    logic [2:0][31:0]                    s5_res_reg;
    logic                                s5_fsat_reg;
    logic signed [TS_W-1:0]              s5_ts_reg [3];
    logic                                s5_wsat_reg;
    sstu_pkg::lane_t                     s5_end_reg;
    sstu_pkg::lane_t                     s5_start_reg;
    logic [sstu_pkg::REM_W-1:0]          s5_dm_reg;
    logic                                s5_par_reg;
    logic [2:0][31:0]                    s5_res_next;
    logic                                s5_fsat_next;
    logic signed [TS_W-1:0]              s5_ts_next [3];
    sstu_pkg::lane_t                     s5_end_next;
    sstu_pkg::lane_t                     s5_start_next;

    always_comb begin
        logic signed [63:0] v;
        logic [32:0]        r;
        s5_fsat_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            v = 64'(s4_fv_reg[k])
              - ((k == 2 && s4_func_reg == sstu_pkg::FUNC_PT_FROM) ? 64'(slice_off) : 64'sd0);
            r = sstu_pkg::sat32(v);
            s5_res_next[k] = r[31:0];
            s5_fsat_next = s5_fsat_next | r[32];
            s5_ts_next[k] = TS_W'(s4_tp_reg[0][k]) + TS_W'(s4_tp_reg[1][k])
                          + TS_W'(s4_tp_reg[2][k]);
        end
        s5_end_next.over = s4_nmag_reg[sstu_pkg::NUM_W-1:sstu_pkg::QUO_W] >= 64'(s4_dm_reg);
        s5_end_next.rem  = s4_nmag_reg[sstu_pkg::QUO_W +: sstu_pkg::REM_W];
        s5_end_next.low  = s4_nmag_reg[sstu_pkg::QUO_W-1:0];
        s5_end_next.quo  = '0;
        s5_end_next.neg  = s4_nneg_reg ^ s4_ddneg_reg;
        s5_start_next.over = s4_smag_reg[sstu_pkg::NUM_W-1:sstu_pkg::QUO_W] >= 64'(s4_dm_reg);
        s5_start_next.rem  = s4_smag_reg[sstu_pkg::QUO_W +: sstu_pkg::REM_W];
        s5_start_next.low  = s4_smag_reg[sstu_pkg::QUO_W-1:0];
        s5_start_next.quo  = '0;
        s5_start_next.neg  = s4_sneg_reg ^ s4_ddneg_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s5_func_reg  <= s4_func_reg;
            s5_res_reg   <= s5_res_next;
            s5_fsat_reg  <= s5_fsat_next;
            s5_ts_reg    <= s5_ts_next;
            s5_wsat_reg  <= s4_wsat_reg;
            s5_end_reg   <= s5_end_next;
            s5_start_reg <= s5_start_next;
            s5_dm_reg    <= s4_dm_reg;
            s5_par_reg   <= s4_par_reg;
        end
    end

    // ---------------- stage 6: to-world round, select by operation ----------------
    sstu_pkg::div_item_t s6_item_reg;
    sstu_pkg::div_item_t s6_item_next;

    always_comb begin
        logic [TS_W-1:0]    m;
        logic [TS_W-1:0]    q;
        logic signed [63:0] v;
        logic [32:0]        r;
        logic [2:0][31:0]   tw_res;
        logic               tw_sat;
        tw_sat = s5_wsat_reg;
        for (int j = 0; j < 3; j++) begin
            m = (s5_ts_reg[j] < 0) ? -s5_ts_reg[j] : s5_ts_reg[j];
            q = (m + (TS_W'(1) << (sstu_pkg::AXIS_FRAC_BITS - 1))) >> sstu_pkg::AXIS_FRAC_BITS;
            v = (s5_ts_reg[j] < 0) ? -$signed(64'(q)) : $signed(64'(q));
            r = sstu_pkg::sat32(v);
            tw_res[j] = r[31:0];
            tw_sat = tw_sat | r[32];
        end
        s6_item_next.is_ray     = 1'b0;
        s6_item_next.par        = 1'b0;
        s6_item_next.sat        = 1'b0;
        s6_item_next.res        = '0;
        s6_item_next.dm         = s5_dm_reg;
        s6_item_next.lane_end   = s5_end_reg;
        s6_item_next.lane_start = s5_start_reg;
        case (s5_func_reg)
            sstu_pkg::FUNC_PT_FROM, sstu_pkg::FUNC_VEC_FROM: begin
                s6_item_next.res = s5_res_reg;
                s6_item_next.sat = s5_fsat_reg;
            end
            sstu_pkg::FUNC_PT_TO, sstu_pkg::FUNC_VEC_TO: begin
                s6_item_next.res = tw_res;
                s6_item_next.sat = tw_sat;
            end
            sstu_pkg::FUNC_RAY: begin
                s6_item_next.is_ray = 1'b1;
                s6_item_next.par    = s5_par_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            s6_item_reg <= s6_item_next;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    sstu_pkg::div_item_t div_reg [sstu_pkg::QUO_W];
    sstu_pkg::div_item_t div_next [sstu_pkg::QUO_W];

    always_comb begin
        for (int i = 0; i < sstu_pkg::QUO_W; i++) begin
            div_next[i] = (i == 0) ? s6_item_reg : div_reg[(i == 0) ? 0 : i - 1];
            div_next[i].lane_end   = sstu_pkg::lane_step(div_next[i].lane_end,
                                                         div_next[i].dm);
            div_next[i].lane_start = sstu_pkg::lane_step(div_next[i].lane_start,
                                                         div_next[i].dm);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < sstu_pkg::QUO_W; i++) begin
            if (en[PRE + i]) begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    // ---------------- output register ----------------
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic               out_par_reg, out_sat_reg;
    logic signed [31:0] out_x_next, out_y_next, out_z_next;
    logic               out_par_next, out_sat_next;

    always_comb begin
        logic [32:0] qe;
        logic [32:0] qs;
        qe = sstu_pkg::lane_finish(div_reg[sstu_pkg::QUO_W-1].lane_end,
                                   div_reg[sstu_pkg::QUO_W-1].dm);
        qs = sstu_pkg::lane_finish(div_reg[sstu_pkg::QUO_W-1].lane_start,
                                   div_reg[sstu_pkg::QUO_W-1].dm);
        out_x_next   = div_reg[sstu_pkg::QUO_W-1].res[0];
        out_y_next   = div_reg[sstu_pkg::QUO_W-1].res[1];
        out_z_next   = div_reg[sstu_pkg::QUO_W-1].res[2];
        out_par_next = 1'b0;
        out_sat_next = div_reg[sstu_pkg::QUO_W-1].sat;
        if (div_reg[sstu_pkg::QUO_W-1].is_ray) begin
            out_z_next = '0;
            if (div_reg[sstu_pkg::QUO_W-1].par) begin
                out_x_next   = '0;
                out_y_next   = '0;
                out_par_next = 1'b1;
                out_sat_next = 1'b0;
            end else begin
                out_x_next   = qs[31:0];
                out_y_next   = qe[31:0];
                out_sat_next = qs[32] | qe[32];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            out_z_reg   <= out_z_next;
            out_par_reg <= out_par_next;
            out_sat_reg <= out_sat_next;
        end
    end

    assign m_out_x         = out_x_reg;
    assign m_out_y         = out_y_reg;
    assign m_out_z         = out_z_reg;
    assign m_parallel_flag = out_par_reg;
    assign m_saturated     = out_sat_reg;

    // ---------------- assertions ----------------
    a_item_count: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> $countones(valid_reg) == $past($countones(valid_reg))
                 + int'($past(s_valid && s_ready)) - int'($past(m_valid && m_ready)))
        else $error("pipeline lost or repeated a beat");

    a_parallel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_parallel_flag |-> m_out_x == 0 && m_out_y == 0 && m_out_z == 0
                                       && !m_saturated)
        else $error("parallel ray result not cleared");

    a_rem_end: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[LASTD] && !div_reg[sstu_pkg::QUO_W-1].lane_end.over
        |-> div_reg[sstu_pkg::QUO_W-1].lane_end.rem < div_reg[sstu_pkg::QUO_W-1].dm)
        else $error("t_end remainder not below divisor");

    a_rem_start: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[LASTD] && !div_reg[sstu_pkg::QUO_W-1].lane_start.over
        |-> div_reg[sstu_pkg::QUO_W-1].lane_start.rem < div_reg[sstu_pkg::QUO_W-1].dm)
        else $error("t_start remainder not below divisor");

endmodule

// ===== test/slice_space_transform_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Slice space transform unit testbench
// Drives point, vector and ray beats through several register settings,
// predicts every result in fixed point and checks the result beats in order,
// with random gaps on both channels and one long hold-off on the output.
// ----------------------------------------------------------------------------
module slice_space_transform_unit_tb;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int         DRAIN_CYCLES  = 60;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [2:0]         func;
        logic signed [31:0] x, y, z, dx, dy, dz;
    } beat_t;

    typedef struct {
        logic signed [31:0] ox, oy, oz;
        logic               par;
        logic               sat;
    } res_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [2:0]                    cfg_index = sstu_pkg::REG_AXIS_ACROSS;
    logic [sstu_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [2:0]                    s_func = sstu_pkg::FUNC_PT_FROM;
    logic signed [31:0]            s_in_x = '0, s_in_y = '0, s_in_z = '0;
    logic signed [31:0]            s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [31:0]            m_out_x, m_out_y, m_out_z;
    logic                          m_parallel_flag, m_saturated;

    // predictor copy of the registers
    logic [sstu_pkg::AXREG_W-1:0]  basis [3];
    logic [31:0]                   vox_len, vox_recip;
    logic signed [31:0]            slice_no;

    beat_t pending_beats[$];
    res_t  expected_res[$];
    int    mismatches = 0;
    int    hold_request = 0;
    int    gap_in = 0, gap_out = 0;
    logic  in_took = 1'b0;

    slice_space_transform_unit DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic wide_t comp(input int k, input int j);
        logic signed [15:0] c;
        c = basis[k][16*j +: 16];
        return wide_t'(c);
    endfunction

    function automatic wide_t scale_round(input wide_t a, input wide_t b, input int sh,
                                          input wide_t lim, inout logic sat);
        logic  neg;
        wide_t mag, q, cap;
        neg = a < 0;
        mag = neg ? -a : a;
        q   = (mag * b + (wide_t'(1) <<< (sh - 1))) >>> sh;
        cap = neg ? lim + 1 : lim;
        if (q > cap) begin
            sat = 1'b1;
            q = cap;
        end
        return neg ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(input wide_t v, inout logic sat);
        if (v > 64'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] quot_round(input wide_t num, input wide_t d,
                                                      inout logic sat);
        logic  neg, over;
        wide_t nm, dm, q, r, cap;
        neg  = (num < 0) != (d < 0);
        nm   = num < 0 ? -num : num;
        dm   = d < 0 ? -d : d;
        q    = nm / dm;
        r    = nm % dm;
        over = q >= (wide_t'(1) <<< 63);
        if (!over && 2 * r >= dm) q = q + 1;
        cap = neg ? (wide_t'(1) <<< 31) : (wide_t'(1) <<< 31) - 1;
        if (over || q > cap) begin
            sat = 1'b1;
            q = cap;
        end
        return neg ? -q : q;
    endfunction

    function automatic res_t transform(input beat_t b);
        res_t  r;
        wide_t p[3], d[3], w[3], v, s, dd, dorg, num, lim60, lim43, soff;
        logic  sat;
        r = '{default: '0};
        sat = 1'b0;
        lim60 = (wide_t'(1) <<< 60) - 1;
        lim43 = (wide_t'(1) <<< 43) - 1;
        soff = wide_t'(slice_no) <<< sstu_pkg::COORD_FRAC_BITS;
        p = '{wide_t'(b.x), wide_t'(b.y), wide_t'(b.z)};
        d = '{wide_t'(b.dx), wide_t'(b.dy), wide_t'(b.dz)};
        case (b.func)
            sstu_pkg::FUNC_PT_FROM, sstu_pkg::FUNC_VEC_FROM: begin
                for (int j = 0; j < 3; j++) begin
                    v = comp(j, 0) * p[0] + comp(j, 1) * p[1] + comp(j, 2) * p[2];
                    v = scale_round(v, wide_t'({1'b0, vox_recip}), sstu_pkg::SH_FW,
                                    lim60, sat);
                    if (b.func == sstu_pkg::FUNC_PT_FROM && j == 2) v = v - soff;
                    case (j)
                        0: r.ox = clamp32(v, sat);
                        1: r.oy = clamp32(v, sat);
                        default: r.oz = clamp32(v, sat);
                    endcase
                end
            end
            sstu_pkg::FUNC_PT_TO, sstu_pkg::FUNC_VEC_TO: begin
                if (b.func == sstu_pkg::FUNC_PT_TO) p[2] = p[2] + soff;
                for (int k = 0; k < 3; k++)
                    w[k] = scale_round(p[k], wide_t'({1'b0, vox_len}),
                                       sstu_pkg::COORD_FRAC_BITS, lim43, sat);
                for (int j = 0; j < 3; j++) begin
                    s = w[0] * comp(0, j) + w[1] * comp(1, j) + w[2] * comp(2, j);
                    s = scale_round(s, 1, sstu_pkg::AXIS_FRAC_BITS, lim60, sat);
                    case (j)
                        0: r.ox = clamp32(s, sat);
                        1: r.oy = clamp32(s, sat);
                        default: r.oz = clamp32(s, sat);
                    endcase
                end
            end
            sstu_pkg::FUNC_RAY: begin
                dd = comp(2, 0) * d[0] + comp(2, 1) * d[1] + comp(2, 2) * d[2];
                if (dd == 0) begin
                    r.par = 1'b1;
                end else begin
                    dorg = comp(2, 0) * p[0] + comp(2, 1) * p[1] + comp(2, 2) * p[2];
                    num = ((wide_t'(slice_no) * wide_t'({1'b0, vox_len})) <<< sstu_pkg::SH_FW)
                        - (dorg <<< sstu_pkg::COORD_FRAC_BITS);
                    r.oy = quot_round(num, dd, sat);
                    r.ox = quot_round(num + (wide_t'({1'b0, vox_len}) <<< sstu_pkg::SH_FW),
                                      dd, sat);
                end
            end
            default: ;
        endcase
        r.sat = sat;
        return r;
    endfunction

    function automatic int pick_gap();
        int u;
        u = $urandom_range(0, 99);
        if (u < 60) return 0;
        if (u < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3, 4: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [sstu_pkg::AXREG_W-1:0] pick_axis();
        logic [sstu_pkg::AXREG_W-1:0] a;
        for (int j = 0; j < 3; j++) begin
            case ($urandom_range(0, 3))
                0: a[16*j +: 16] = 16'($urandom);
                1: a[16*j +: 16] = 16'($signed($urandom_range(0, 32768)) - 16384);
                2: a[16*j +: 16] = 16'sh8000;
                default: a[16*j +: 16] = '0;
            endcase
        end
        return a;
    endfunction

    function automatic beat_t pick_beat();
        beat_t b;
        int    u;
        u = $urandom_range(0, 99);
        b.func = u < 94 ? 3'(u % 5) : 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        b.x = pick_coord();
        b.y = pick_coord();
        b.z = pick_coord();
        b.dx = pick_coord();
        b.dy = pick_coord();
        b.dz = pick_coord();
        // steer some rays parallel to the slab
        if (b.func == sstu_pkg::FUNC_RAY && $urandom_range(0, 9) == 0) begin
            b.dx = 0;
            b.dy = 0;
            b.dz = 0;
        end
        return b;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [sstu_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            sstu_pkg::REG_AXIS_ACROSS: basis[0] = val;
            sstu_pkg::REG_AXIS_UP:     basis[1] = val;
            sstu_pkg::REG_AXIS_DEPTH:  basis[2] = val;
            sstu_pkg::REG_VOXEL_SIZE:  vox_len = val[31:0];
            sstu_pkg::REG_INV_VOXEL:   vox_recip = val[31:0];
            default:                   slice_no = val[31:0];
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || expected_res.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // driver: offer beats at the falling edge
    always @(negedge aclk) begin
        if (s_valid && !in_took) begin
            // hold
        end else if (gap_in > 0) begin
            s_valid <= 1'b0;
            gap_in <= gap_in - 1;
        end else if (pending_beats.size() != 0) begin
            beat_t b;
            b = pending_beats.pop_front();
            s_valid <= 1'b1;
            s_func <= b.func;
            s_in_x <= b.x;
            s_in_y <= b.y;
            s_in_z <= b.z;
            s_dir_x <= b.dx;
            s_dir_y <= b.dy;
            s_dir_z <= b.dz;
            gap_in <= pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            m_ready <= 1'b0;
            hold_request <= hold_request - 1;
        end else if (gap_out > 0) begin
            m_ready <= 1'b0;
            gap_out <= gap_out - 1;
        end else begin
            m_ready <= 1'b1;
            gap_out <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        beat_t b;
        res_t  e;
        in_took = s_valid && s_ready && aresetn;
        if (in_took) begin
            b = '{s_func, s_in_x, s_in_y, s_in_z, s_dir_x, s_dir_y, s_dir_z};
            expected_res.push_back(transform(b));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
            end else begin
                e = expected_res.pop_front();
                if (m_out_x !== e.ox || m_out_y !== e.oy || m_out_z !== e.oz
                        || m_parallel_flag !== e.par || m_saturated !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h p%b s%b got %h %h %h p%b s%b",
                                 e.ox, e.oy, e.oz, e.par, e.sat, m_out_x, m_out_y,
                                 m_out_z, m_parallel_flag, m_saturated);
                end
            end
        end
    end

    initial begin
        beat_t b;
        basis[0] = 48'h0000_0000_4000;
        basis[1] = 48'h0000_4000_0000;
        basis[2] = 48'h4000_0000_0000;
        vox_len = 32'h0001_0000;
        vox_recip = 32'h0001_0000;
        slice_no = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: every operation at the coordinate extremes
        for (int f = 0; f < 8; f++) begin
            b = '{3'(f), 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_8000,
                  32'sh0001_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
            pending_beats.push_back(b);
        end
        b = '{sstu_pkg::FUNC_RAY, 32'sh0003_0000, 0, 32'sh0002_0000, 32'sh0001_0000, 0, 0};
        pending_beats.push_back(b);   // ray parallel to the slab
        b = '{sstu_pkg::FUNC_RAY, 0, 0, 32'sh0002_8000, 0, 0, -32'sh0001_0000};
        pending_beats.push_back(b);
        b = '{sstu_pkg::FUNC_RAY, 0, 0, 0, 0, 0, 1};
        pending_beats.push_back(b);   // tiny direction saturates
        b = '{sstu_pkg::FUNC_PT_FROM, -32'sh0000_8000, 32'sh0000_8000, -1, 0, 0, 0};
        pending_beats.push_back(b);   // coordinates of -0.5, +0.5 and -1 LSB
        b = '{sstu_pkg::FUNC_VEC_TO, 0, 0, 0, 0, 0, 0};
        pending_beats.push_back(b);
        wait_drained();

        write_reg(sstu_pkg::REG_SLICE_INDEX, sstu_pkg::CFG_W'(32'h7FFF_FFFF));
        write_reg(sstu_pkg::REG_VOXEL_SIZE, sstu_pkg::CFG_W'(32'hFFFF_FFFF));
        write_reg(sstu_pkg::REG_INV_VOXEL, sstu_pkg::CFG_W'(32'hFFFF_FFFF));
        for (int f = 0; f < 5; f++) begin
            b = '{3'(f), 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                  0, 0, 32'sh8000_0000};
            pending_beats.push_back(b);
        end
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(sstu_pkg::REG_SLICE_INDEX, sstu_pkg::CFG_W'(32'h8000_0000));
                    write_reg(sstu_pkg::REG_VOXEL_SIZE, sstu_pkg::CFG_W'(1));
                    write_reg(sstu_pkg::REG_INV_VOXEL, sstu_pkg::CFG_W'(1));
                end
                1: begin
                    write_reg(sstu_pkg::REG_AXIS_ACROSS, 48'h8000_8000_8000);
                    write_reg(sstu_pkg::REG_AXIS_UP, 48'h7FFF_7FFF_7FFF);
                    write_reg(sstu_pkg::REG_AXIS_DEPTH, 48'h8000_7FFF_8000);
                    write_reg(sstu_pkg::REG_SLICE_INDEX, sstu_pkg::CFG_W'(0));
                end
                default: begin
                    write_reg(sstu_pkg::REG_AXIS_ACROSS, pick_axis());
                    write_reg(sstu_pkg::REG_AXIS_UP, pick_axis());
                    write_reg(sstu_pkg::REG_AXIS_DEPTH, pick_axis());
                    write_reg(sstu_pkg::REG_VOXEL_SIZE,
                              sstu_pkg::CFG_W'($urandom_range(1, 32'h0004_0000)));
                    write_reg(sstu_pkg::REG_INV_VOXEL,
                              sstu_pkg::CFG_W'($urandom_range(1, 32'h0004_0000)));
                    write_reg(sstu_pkg::REG_SLICE_INDEX,
                              sstu_pkg::CFG_W'($signed($urandom_range(0, 2000)) - 1000));
                end
            endcase
            for (int i = 0; i < 200; i++) pending_beats.push_back(pick_beat());
            // let the pipeline fill and back up against the input
            if (ph == 2) hold_request = 150;
            wait_drained();
        end

        if (mismatches == 0 && expected_res.size() == 0) begin
            $display("PASS slice_space_transform_unit");
        end else begin
            $display("FAIL slice_space_transform_unit");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("FAIL slice_space_transform_unit");
        $finish;
    end

endmodule

// ===== slice_space_transform_unit.f =====
src/sstu_pkg.sv
src/slice_space_transform_unit.sv
test/slice_space_transform_unit_tb.sv
